FILE: src/pam_pkg.sv
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types, codes and sizes of the polynomial add/multiply unit.
// ----------------------------------------------------------------------------
package pam_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int COEF_WIDTH = 16;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int RAM_AW     = $clog2(DEPTH);

  localparam int IDX_W   = 4;
  localparam int POW_W   = 5;
  localparam int VALUE_W = 36;
  localparam int IN_W    = 16;
  localparam int OP_W    = 2;
  localparam int STEP_W  = 4;
  localparam int PADDR_W = 3;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [POW_W-1:0]             pow_t;
  typedef logic [STEP_W-1:0]            step_t;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

  localparam logic REG_DEGREE_A = 1'b0;
  localparam logic REG_DEGREE_B = 1'b1;

  localparam logic KIND_SUM  = 1'b0;
  localparam logic KIND_PROD = 1'b1;

  localparam logic [1:0] K_HOLD = 2'd0;
  localparam logic [1:0] K_CLR  = 2'd1;
  localparam logic [1:0] K_INC  = 2'd2;

  localparam logic [1:0] I_HOLD  = 2'd0;
  localparam logic [1:0] I_START = 2'd1;
  localparam logic [1:0] I_INC   = 2'd2;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_CLR  = 2'd1;
  localparam logic [1:0] ACC_MAC  = 2'd2;

  localparam logic [2:0] COND_NONE      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_NOT_RUN   = 3'd2;
  localparam logic [2:0] COND_K_NE_TOP  = 3'd3;
  localparam logic [2:0] COND_K_NE_PEND = 3'd4;
  localparam logic [2:0] COND_I_NE_END  = 3'd5;

  typedef struct packed {
    logic       take_in;
    logic       wait_out;
    logic       emit;
    logic       emit_kind;
    logic [1:0] k_op;
    logic [1:0] i_op;
    logic [1:0] acc_op;
    logic       rd_prod;
    logic [2:0] cond;
    step_t      target;
  } cw_t;

  typedef struct packed {
    cw_t  cw;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic run_req;
    logic k_is_top;
    logic k_is_pend;
    logic i_is_end;
    logic out_free;
  } stat_t;

endpackage

FILE: src/polynomial_add_multiply_unit.sv
// ----------------------------------------------------------------------------
// polynomial_add_multiply_unit
// Loads two coefficient stores, then emits their sum and their convolution.
// ----------------------------------------------------------------------------
// A run request first emits the sum terms, each through a read step and an
// emit step, then the product terms; each product term passes a start step
// and an emit step plus a read and a multiply-accumulate step per
// contributing coefficient pair on the single multiply-accumulate. A run is
// paced by the microcode loop around the multiply-accumulate and the store
// read ports. Requests are taken only between runs. Reading a store entry
// inside the set degree that was never loaded gives an undefined
// coefficient.
// ----------------------------------------------------------------------------
module polynomial_add_multiply_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pam_pkg::OP_W-1:0]          in_opcode,
  input  logic [pam_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [pam_pkg::IN_W-1:0]   in_coef_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_result_kind,
  output logic [pam_pkg::POW_W-1:0]         out_result_power,
  output logic signed [pam_pkg::VALUE_W-1:0] out_result_value,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pam_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  pam_pkg::idx_t  degree_a_r;
  pam_pkg::idx_t  degree_b_r;
  pam_pkg::idx_t  deg_a;
  pam_pkg::idx_t  deg_b;
  pam_pkg::ctl_t  ctl;
  pam_pkg::stat_t stat;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_a_r <= '0;
      degree_b_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == pam_pkg::REG_DEGREE_A) begin
        degree_a_r <= pwdata[pam_pkg::IDX_W-1:0];
      end else begin
        degree_b_r <= pwdata[pam_pkg::IDX_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == pam_pkg::REG_DEGREE_B) ?
                  {28'd0, degree_b_r} : {28'd0, degree_a_r};

  assign deg_a = ({1'b0, degree_a_r} > 5'(pam_pkg::MAX_DEGREE)) ?
                 pam_pkg::IDX_W'(pam_pkg::MAX_DEGREE) : degree_a_r;
  assign deg_b = ({1'b0, degree_b_r} > 5'(pam_pkg::MAX_DEGREE)) ?
                 pam_pkg::IDX_W'(pam_pkg::MAX_DEGREE) : degree_b_r;

  pam_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  pam_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .deg_a            (deg_a),
    .deg_b            (deg_b),
    .in_valid         (in_valid),
    .in_opcode        (in_opcode),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .out_stall        (out_stall),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_result_power (out_result_power),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

  assign in_stall = !ctl.cw.take_in;

endmodule

FILE: src/pam_ram.sv
// ----------------------------------------------------------------------------
// pam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pam_seq.sv
// ----------------------------------------------------------------------------
// pam_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module pam_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  pam_pkg::stat_t  stat,
  output pam_pkg::ctl_t   ctl
);

  localparam pam_pkg::step_t ST_IDLE       = 4'd0;
  localparam pam_pkg::step_t ST_SUM_INIT   = 4'd1;
  localparam pam_pkg::step_t ST_SUM_READ   = 4'd2;
  localparam pam_pkg::step_t ST_SUM_EMIT   = 4'd3;
  localparam pam_pkg::step_t ST_PROD_INIT  = 4'd4;
  localparam pam_pkg::step_t ST_PROD_START = 4'd5;
  localparam pam_pkg::step_t ST_PROD_READ  = 4'd6;
  localparam pam_pkg::step_t ST_PROD_MAC   = 4'd7;
  localparam pam_pkg::step_t ST_PROD_EMIT  = 4'd8;
  localparam pam_pkg::step_t ST_DONE       = 4'd9;

  function automatic pam_pkg::cw_t rom_word(input pam_pkg::step_t step);
    pam_pkg::cw_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = pam_pkg::COND_NOT_RUN;
        w.target  = ST_IDLE;
      end
      ST_SUM_INIT: begin
        w.k_op = pam_pkg::K_CLR;
      end
      ST_SUM_READ: begin
        w.rd_prod = 1'b0;
      end
      ST_SUM_EMIT: begin
        w.wait_out  = 1'b1;
        w.emit      = 1'b1;
        w.emit_kind = pam_pkg::KIND_SUM;
        w.k_op      = pam_pkg::K_INC;
        w.cond      = pam_pkg::COND_K_NE_TOP;
        w.target    = ST_SUM_READ;
      end
      ST_PROD_INIT: begin
        w.k_op = pam_pkg::K_CLR;
      end
      ST_PROD_START: begin
        w.acc_op = pam_pkg::ACC_CLR;
        w.i_op   = pam_pkg::I_START;
      end
      ST_PROD_READ: begin
        w.rd_prod = 1'b1;
      end
      ST_PROD_MAC: begin
        w.rd_prod = 1'b1;
        w.acc_op  = pam_pkg::ACC_MAC;
        w.i_op    = pam_pkg::I_INC;
        w.cond    = pam_pkg::COND_I_NE_END;
        w.target  = ST_PROD_READ;
      end
      ST_PROD_EMIT: begin
        w.wait_out  = 1'b1;
        w.emit      = 1'b1;
        w.emit_kind = pam_pkg::KIND_PROD;
        w.k_op      = pam_pkg::K_INC;
        w.cond      = pam_pkg::COND_K_NE_PEND;
        w.target    = ST_PROD_START;
      end
      ST_DONE: begin
        w.cond   = pam_pkg::COND_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = pam_pkg::COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  pam_pkg::step_t pc_r;
  pam_pkg::step_t pc_nxt;
  pam_pkg::cw_t   cw;
  logic           fire;
  logic           taken;

  assign cw   = rom_word(pc_r);
  assign fire = !(cw.wait_out && !stat.out_free);

  always_comb begin
    case (cw.cond)
      pam_pkg::COND_NONE:      taken = 1'b0;
      pam_pkg::COND_ALWAYS:    taken = 1'b1;
      pam_pkg::COND_NOT_RUN:   taken = !stat.run_req;
      pam_pkg::COND_K_NE_TOP:  taken = !stat.k_is_top;
      pam_pkg::COND_K_NE_PEND: taken = !stat.k_is_pend;
      pam_pkg::COND_I_NE_END:  taken = !stat.i_is_end;
      default:                 taken = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (fire) begin
      pc_nxt = taken ? cw.target : pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.cw   = cw;
  assign ctl.fire = fire;

endmodule

FILE: src/pam_datapath.sv
// ----------------------------------------------------------------------------
// pam_datapath
// Coefficient stores, index counters, multiply-accumulate and result register.
// ----------------------------------------------------------------------------
module pam_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pam_pkg::ctl_t                 ctl,
  input  pam_pkg::idx_t                 deg_a,
  input  pam_pkg::idx_t                 deg_b,
  input  logic                          in_valid,
  input  logic [pam_pkg::OP_W-1:0]      in_opcode,
  input  pam_pkg::idx_t                 in_coef_index,
  input  logic signed [pam_pkg::IN_W-1:0] in_coef_value,
  input  logic                          out_stall,
  output pam_pkg::stat_t                stat,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output pam_pkg::pow_t                 out_result_power,
  output logic signed [pam_pkg::VALUE_W-1:0] out_result_value,
  output logic                          out_last
);

  pam_pkg::pow_t   k_r;
  pam_pkg::pow_t   k_nxt;
  pam_pkg::idx_t   i_r;
  pam_pkg::idx_t   i_nxt;
  pam_pkg::value_t acc_r;
  pam_pkg::value_t acc_nxt;

  logic            out_valid_r;
  logic            out_kind_r;
  pam_pkg::pow_t   out_power_r;
  pam_pkg::value_t out_value_r;
  logic            out_last_r;

  logic            req;
  logic            we_a;
  logic            we_b;
  pam_pkg::coef_t  wr_coef;
  pam_pkg::pow_t   k_minus_i;
  pam_pkg::pow_t   k_minus_db;
  pam_pkg::idx_t   ra_a;
  pam_pkg::idx_t   ra_b;
  logic [pam_pkg::COEF_WIDTH-1:0] rd_a;
  logic [pam_pkg::COEF_WIDTH-1:0] rd_b;
  pam_pkg::coef_t  a_s;
  pam_pkg::coef_t  b_s;
  logic signed [2*pam_pkg::COEF_WIDTH-1:0] prod;
  pam_pkg::value_t sum;
  pam_pkg::idx_t   top;
  pam_pkg::pow_t   pend;
  pam_pkg::idx_t   i_end;
  logic            out_free;
  logic            do_emit;

  assign req     = ctl.cw.take_in && in_valid;
  assign wr_coef = pam_pkg::coef_t'(in_coef_value);
  assign we_a    = ctl.fire && req && (in_opcode == pam_pkg::OP_LOAD_A)
                   && (in_coef_index <= deg_a);
  assign we_b    = ctl.fire && req && (in_opcode == pam_pkg::OP_LOAD_B)
                   && (in_coef_index <= deg_b);

  assign k_minus_i  = k_r - {1'b0, i_r};
  assign k_minus_db = k_r - {1'b0, deg_b};
  assign ra_a       = ctl.cw.rd_prod ? i_r : k_r[pam_pkg::IDX_W-1:0];
  assign ra_b       = ctl.cw.rd_prod ? k_minus_i[pam_pkg::IDX_W-1:0]
                                     : k_r[pam_pkg::IDX_W-1:0];

  pam_ram #(
    .WIDTH (pam_pkg::COEF_WIDTH),
    .DEPTH (pam_pkg::DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (in_coef_index[pam_pkg::RAM_AW-1:0]),
    .wdata (wr_coef),
    .raddr (ra_a[pam_pkg::RAM_AW-1:0]),
    .rdata (rd_a)
  );

  pam_ram #(
    .WIDTH (pam_pkg::COEF_WIDTH),
    .DEPTH (pam_pkg::DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (in_coef_index[pam_pkg::RAM_AW-1:0]),
    .wdata (wr_coef),
    .raddr (ra_b[pam_pkg::RAM_AW-1:0]),
    .rdata (rd_b)
  );

  assign a_s  = pam_pkg::coef_t'(rd_a);
  assign b_s  = pam_pkg::coef_t'(rd_b);
  assign prod = a_s * b_s;

  always_comb begin
    sum = '0;
    if (k_r <= {1'b0, deg_a}) begin
      sum = sum + pam_pkg::value_t'(a_s);
    end
    if (k_r <= {1'b0, deg_b}) begin
      sum = sum + pam_pkg::value_t'(b_s);
    end
  end

  assign top   = (deg_a > deg_b) ? deg_a : deg_b;
  assign pend  = {1'b0, deg_a} + {1'b0, deg_b};
  assign i_end = (k_r > {1'b0, deg_a}) ? deg_a : k_r[pam_pkg::IDX_W-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign do_emit  = ctl.fire && ctl.cw.emit;

  always_comb begin
    k_nxt   = k_r;
    i_nxt   = i_r;
    acc_nxt = acc_r;
    if (ctl.fire) begin
      case (ctl.cw.k_op)
        pam_pkg::K_CLR: k_nxt = '0;
        pam_pkg::K_INC: k_nxt = k_r + 5'd1;
        default:        k_nxt = k_r;
      endcase
      case (ctl.cw.i_op)
        pam_pkg::I_START: i_nxt = (k_r > {1'b0, deg_b}) ?
                                  k_minus_db[pam_pkg::IDX_W-1:0] : '0;
        pam_pkg::I_INC:   i_nxt = i_r + 4'd1;
        default:          i_nxt = i_r;
      endcase
      case (ctl.cw.acc_op)
        pam_pkg::ACC_CLR: acc_nxt = '0;
        pam_pkg::ACC_MAC: acc_nxt = acc_r + pam_pkg::value_t'(prod);
        default:          acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_kind_r  <= ctl.cw.emit_kind;
      out_power_r <= k_r;
      out_value_r <= (ctl.cw.emit_kind == pam_pkg::KIND_PROD) ? acc_r : sum;
      out_last_r  <= (ctl.cw.emit_kind == pam_pkg::KIND_PROD) && (k_r == pend);
    end
  end

  assign stat.run_req   = in_valid && (in_opcode == pam_pkg::OP_RUN);
  assign stat.k_is_top  = (k_r == {1'b0, top});
  assign stat.k_is_pend = (k_r == pend);
  assign stat.i_is_end  = (i_r == i_end);
  assign stat.out_free  = out_free;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_power = out_power_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

endmodule

FILE: src/pam_checker.sv
// ----------------------------------------------------------------------------
// pam_checker
// Port-level checks of the polynomial add/multiply unit, bound to the top.
// ----------------------------------------------------------------------------
module pam_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [pam_pkg::OP_W-1:0]          in_opcode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_result_kind,
  input logic [pam_pkg::POW_W-1:0]         out_result_power,
  input logic signed [pam_pkg::VALUE_W-1:0] out_result_value,
  input logic                              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_result_power) && $stable(out_result_kind) && $stable(out_last))
    else $error("stalled result changed");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == pam_pkg::OP_RUN) |=> in_stall)
    else $error("request taken during a run");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_result_kind == pam_pkg::KIND_PROD))
    else $error("last flag on a sum term");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last && !in_stall
      && !(in_valid && (in_opcode == pam_pkg::OP_RUN)) |=> !in_stall)
    else $error("not ready for requests after final term");

endmodule

bind polynomial_add_multiply_unit pam_checker u_pam_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_result_power (out_result_power),
  .out_result_value (out_result_value),
  .out_last         (out_last)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polynomial_add_multiply_unit. Coefficient loads and
// run requests go in through the valid/stall input channel; the degrees are
// set over the APB port while the unit is idle. A local copy of both stores
// computes the sum and convolution terms of every run, and each term that
// leaves the unit is compared field by field with the oldest term still due.
// Directed cases come first, then random traffic under several idle/stall
// mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [pam_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic            kind;
    pam_pkg::pow_t   power;
    pam_pkg::value_t value;
    logic            last;
  } term_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [pam_pkg::OP_W-1:0]         in_opcode = pam_pkg::OP_LOAD_A;
  pam_pkg::idx_t                    in_coef_index = '0;
  logic signed [pam_pkg::IN_W-1:0]  in_coef_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_result_kind;
  pam_pkg::pow_t                    out_result_power;
  pam_pkg::value_t                  out_result_value;
  logic                             out_last;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [pam_pkg::PADDR_W-1:0]      paddr = '0;
  logic [31:0]                      pwdata = '0;
  logic [31:0]                      prdata;
  logic                             pready;

  term_t          due_terms[$];
  pam_pkg::coef_t coef_a [pam_pkg::DEPTH];
  pam_pkg::coef_t coef_b [pam_pkg::DEPTH];
  bit             loaded_a [pam_pkg::DEPTH];
  bit             loaded_b [pam_pkg::DEPTH];
  pam_pkg::idx_t  deg_a = '0;
  pam_pkg::idx_t  deg_b = '0;
  int             errors = 0;
  int             taken_count = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             hold_req = 0;
  int             hold_left = 0;

  polynomial_add_multiply_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_coef_index    (in_coef_index),
    .in_coef_value    (in_coef_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_power (out_result_power),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  function automatic void polynomial_step(logic [pam_pkg::OP_W-1:0] op,
                                          pam_pkg::idx_t idx, pam_pkg::coef_t val);
    longint acc [2*pam_pkg::MAX_DEGREE+1];
    longint s;
    int     top;
    int     span;
    case (op)
      pam_pkg::OP_LOAD_A: if (idx <= deg_a) begin
        coef_a[idx]   = val;
        loaded_a[idx] = 1'b1;
        taken_count++;
      end
      pam_pkg::OP_LOAD_B: if (idx <= deg_b) begin
        coef_b[idx]   = val;
        loaded_b[idx] = 1'b1;
        taken_count++;
      end
      pam_pkg::OP_RUN: begin
        taken_count++;
        top  = (deg_a > deg_b) ? int'(deg_a) : int'(deg_b);
        span = int'(deg_a) + int'(deg_b);
        for (int i = 0; i <= top; i++) begin
          s = 0;
          if (i <= deg_a) s += coef_a[i];
          if (i <= deg_b) s += coef_b[i];
          due_terms.push_back('{kind: pam_pkg::KIND_SUM, power: pam_pkg::pow_t'(i),
                                value: pam_pkg::value_t'(s), last: 1'b0});
        end
        foreach (acc[k]) acc[k] = 0;
        for (int i = 0; i <= deg_a; i++)
          for (int j = 0; j <= deg_b; j++)
            acc[i+j] += longint'(coef_a[i]) * longint'(coef_b[j]);
        for (int k = 0; k <= span; k++)
          due_terms.push_back('{kind: pam_pkg::KIND_PROD, power: pam_pkg::pow_t'(k),
                                value: pam_pkg::value_t'(acc[k]), last: (k == span)});
      end
      default: ;
    endcase
  endfunction

  function automatic pam_pkg::coef_t random_coef();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return pam_pkg::coef_t'($urandom());
    endcase
  endfunction

  function automatic pam_pkg::idx_t pick_degree();
    return ($urandom_range(9) == 0) ? pam_pkg::idx_t'(pam_pkg::MAX_DEGREE)
                                    : pam_pkg::idx_t'($urandom_range(4));
  endfunction

  task automatic send_request(input logic [pam_pkg::OP_W-1:0] op, input pam_pkg::idx_t idx,
                              input pam_pkg::coef_t val);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_coef_index <= idx;
    in_coef_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polynomial_step(op, idx, val);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    release_input();
    while (due_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input pam_pkg::idx_t val);
    logic [31:0] word;
    word      = $urandom();
    word[3:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_degrees(input pam_pkg::idx_t da, input pam_pkg::idx_t db);
    settle();
    apb_write(pam_pkg::REG_DEGREE_A, da);
    deg_a = da;
    apb_write(pam_pkg::REG_DEGREE_B, db);
    deg_b = db;
  endtask

  task automatic run_request();
    for (int i = 0; i <= deg_a; i++)
      if (!loaded_a[i]) send_request(pam_pkg::OP_LOAD_A, pam_pkg::idx_t'(i), random_coef());
    for (int i = 0; i <= deg_b; i++)
      if (!loaded_b[i]) send_request(pam_pkg::OP_LOAD_B, pam_pkg::idx_t'(i), random_coef());
    send_request(pam_pkg::OP_RUN, pam_pkg::idx_t'($urandom()), pam_pkg::coef_t'($urandom()));
  endtask

  task automatic test_single_terms();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(pam_pkg::OP_LOAD_A, 4'd0, 16'sh8000);
    send_request(pam_pkg::OP_LOAD_B, 4'd0, 16'sh8000);
    send_request(OP_UNUSED, 4'd0, 16'sh0005);
    send_request(pam_pkg::OP_LOAD_A, 4'd9, 16'sh0001);
    send_request(pam_pkg::OP_RUN, 4'd0, 16'sh0000);
  endtask

  task automatic test_wide_operand();
    set_degrees(pam_pkg::idx_t'(pam_pkg::MAX_DEGREE), 4'd1);
    for (int i = 0; i <= pam_pkg::MAX_DEGREE; i++)
      send_request(pam_pkg::OP_LOAD_A, pam_pkg::idx_t'(i), (i % 2) ? 16'sh7fff : 16'sh8000);
    send_request(pam_pkg::OP_LOAD_B, 4'd0, 16'sh7fff);
    send_request(pam_pkg::OP_LOAD_B, 4'd15, 16'sh7fff);
    send_request(pam_pkg::OP_LOAD_B, 4'd1, 16'sh8000);
    send_request(pam_pkg::OP_RUN, 4'd15, 16'shffff);
  endtask

  task automatic test_random_traffic(input int items, input int idle, input int stall);
    int start;
    int n;
    idle_pct  = idle;
    stall_pct = stall;
    set_degrees(pick_degree(), pick_degree());
    start = taken_count;
    while (taken_count - start < items) begin
      n = $urandom_range(99);
      if (n < 70) begin
        repeat ($urandom_range(0, int'(deg_a) + int'(deg_b) + 2)) begin
          if ($urandom_range(1))
            send_request(pam_pkg::OP_LOAD_A, pam_pkg::idx_t'($urandom_range(0, deg_a)),
                         random_coef());
          else
            send_request(pam_pkg::OP_LOAD_B, pam_pkg::idx_t'($urandom_range(0, deg_b)),
                         random_coef());
        end
        run_request();
      end else if (n < 78) begin
        set_degrees(pick_degree(), pick_degree());
      end else if (n < 86) begin
        send_request(OP_UNUSED, pam_pkg::idx_t'($urandom()), pam_pkg::coef_t'($urandom()));
      end else if (n < 96) begin
        send_request($urandom_range(1) ? pam_pkg::OP_LOAD_A : pam_pkg::OP_LOAD_B,
                     pam_pkg::idx_t'($urandom()), random_coef());
      end else begin
        run_request();
      end
    end
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    set_degrees(4'd3, 4'd2);
    @(negedge clk);
    hold_req = 500;
    run_request();
    repeat (8)
      send_request($urandom_range(1) ? pam_pkg::OP_LOAD_A : pam_pkg::OP_LOAD_B,
                   pam_pkg::idx_t'($urandom_range(0, 2)), random_coef());
    run_request();
    settle();
    run_request();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_terms
    term_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_terms.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d power %0d %s",
                 $time, out_result_kind, out_result_power,
                 $sformatf("value %0h last %0d", out_result_value, out_last));
      end else begin
        want = due_terms.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("result_power", want.power, out_result_power);
        check_field("result_value", longint'(want.value), longint'(out_result_value));
        check_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    #4000000;
    $display("** polynomial_add_multiply_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_terms();
    test_wide_operand();
    test_random_traffic(65, 0, 0);
    test_random_traffic(65, 49, 0);
    test_random_traffic(65, 0, 49);
    test_random_traffic(65, 14, 14);
    test_backpressure();
    release_input();
    while (due_terms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** polynomial_add_multiply_unit: PASSED **");
    end else begin
      $display("** polynomial_add_multiply_unit: FAILED **");
    end
    $finish;
  end
endmodule
